FILE: design/rdb_pkg.sv
// ----------------------------------------------------------------------------
// rdb_pkg: shared definitions for the ring deque buffer
// Operation codes, status codes, field widths and the decode flag bundle.
// ----------------------------------------------------------------------------
package rdb_pkg;

  localparam int DEPTH_DEF = 1024;

  localparam int OP_W   = 3;
  localparam int DATA_W = 16;
  localparam int CNT_W  = 10;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_INC    = 3'd1;
  localparam logic [OP_W-1:0] OP_TAKE   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP    = 3'd3;
  localparam logic [OP_W-1:0] OP_UNTAKE = 3'd4;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_REFUSED = 1'b1;

  // Per-word decode result handed from the pointer unit to the datapath.
  typedef struct packed {
    logic refused;   // operation rejected, no state change
    logic wr_en;     // word writes the ring entry at its address
    logic wr_inc;    // write value is old entry plus operand
    logic ret_data;  // word returns the entry read at its address
  } dec_t;

endpackage

FILE: design/rdb_mem.sv
// ----------------------------------------------------------------------------
// rdb_mem: ring entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdb_mem #(
  parameter int DEPTH = rdb_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              rd_en,
  input  logic [AW-1:0]                     rd_addr,
  output logic signed [rdb_pkg::DATA_W-1:0] rd_data,
  input  logic                              wr_en,
  input  logic [AW-1:0]                     wr_addr,
  input  logic signed [rdb_pkg::DATA_W-1:0] wr_data
);

  logic signed [rdb_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/rdb_ptr.sv
// ----------------------------------------------------------------------------
// rdb_ptr: head, tail and fill tracking
// Decodes each word against the current pointers and advances them on accept.
// ----------------------------------------------------------------------------
module rdb_ptr #(
  parameter int DEPTH = rdb_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [rdb_pkg::OP_W-1:0] opcode,
  output rdb_pkg::dec_t            dec,
  output logic [AW-1:0]            addr,
  output logic [AW-1:0]            fill_after
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] head;
  logic [AW-1:0] tail;
  logic [AW-1:0] fill;
  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic [AW-1:0] fill_next;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] tail_inc;
  logic [AW-1:0] tail_dec;

  assign head_inc = (head == LAST) ? '0 : head + 1'b1;
  assign head_dec = (head == '0) ? LAST : head - 1'b1;
  assign tail_inc = (tail == LAST) ? '0 : tail + 1'b1;
  assign tail_dec = (tail == '0) ? LAST : tail - 1'b1;

  always_comb begin
    dec        = '0;
    addr       = tail;
    head_next  = head;
    tail_next  = tail;
    fill_next  = fill;
    unique case (opcode)
      rdb_pkg::OP_ADD: begin
        addr = head;
        if (head_inc == tail) begin
          dec.refused = 1'b1;
        end else begin
          dec.wr_en = 1'b1;
          head_next = head_inc;
          fill_next = fill + 1'b1;
        end
      end
      rdb_pkg::OP_INC: begin
        addr = head_dec;
        if (head == tail) begin
          dec.refused = 1'b1;
        end else begin
          dec.wr_en  = 1'b1;
          dec.wr_inc = 1'b1;
        end
      end
      rdb_pkg::OP_TAKE: begin
        addr = tail;
        if (fill == '0) begin
          dec.refused = 1'b1;
        end else begin
          dec.ret_data = 1'b1;
          tail_next    = tail_inc;
          fill_next    = fill - 1'b1;
        end
      end
      rdb_pkg::OP_POP: begin
        addr = head_dec;
        if (fill == '0) begin
          dec.refused = 1'b1;
        end else begin
          dec.ret_data = 1'b1;
          head_next    = head_dec;
          fill_next    = fill - 1'b1;
        end
      end
      rdb_pkg::OP_UNTAKE: begin
        if (fill == LAST) begin
          dec.refused = 1'b1;
        end else begin
          tail_next = tail_dec;
          fill_next = fill + 1'b1;
        end
      end
      default: begin
        dec.refused = 1'b1;
      end
    endcase
  end

  assign fill_after = fill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else if (accept) begin
      head <= head_next;
      tail <= tail_next;
      fill <= fill_next;
    end
  end

endmodule

FILE: design/ring_deque_buffer.sv
// ----------------------------------------------------------------------------
// ring_deque_buffer: ring of signed 16-bit entries used as a deque
// Add, increment-newest, take, pop and untake, one result word per input word.
// ----------------------------------------------------------------------------
// Usage: every input word (opcode, value) produces exactly one result word
// (status, data, count). The block accepts one word per clock cycle when the
// result side keeps up; an accepted word is registered in stage 1 and then
// in the result register, where its result word is presented. Stage 1 is
// set by the entry memory: its read data is registered at accept, and the
// read-modify-write of increment completes in the following stage, with a
// bypass from that stage's write back to the next word's read. Pointer and
// fill checks are done at accept, so back-to-back words see each other's
// effects in order. The ring holds DEPTH-1 entries; the entry memory has no
// reset, and reading a slot uncovered by untake that was never written
// returns unspecified data. Count reports the low ten bits of the fill level
// after the operation.
// ----------------------------------------------------------------------------
module ring_deque_buffer #(
  parameter int DEPTH = rdb_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rdb_pkg::OP_W-1:0]          opcode,
  input  logic signed [rdb_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              status,
  output logic signed [rdb_pkg::DATA_W-1:0] data,
  output logic [rdb_pkg::CNT_W-1:0]         count
);

  localparam int AW = $clog2(DEPTH);

  logic                              accept;
  logic                              adv;
  rdb_pkg::dec_t                     dec;
  logic [AW-1:0]                     addr;
  logic [AW-1:0]                     fill_after;

  // Stage 1: word waiting on its memory read.
  logic                              s1_valid;
  rdb_pkg::dec_t                     s1_dec;
  logic [AW-1:0]                     s1_addr;
  logic signed [rdb_pkg::DATA_W-1:0] s1_value;
  logic [AW-1:0]                     s1_fill;

  logic signed [rdb_pkg::DATA_W-1:0] rd_data;
  logic                              byp_hit;
  logic signed [rdb_pkg::DATA_W-1:0] byp_data;
  logic signed [rdb_pkg::DATA_W-1:0] cur;
  logic                              wr_en;
  logic signed [rdb_pkg::DATA_W-1:0] wr_data;
  logic [AW+rdb_pkg::CNT_W-1:0]      fill_ext;

  // Advance stage 1 whenever the result register is free or being drained.
  assign adv      = !out_valid || out_ready;
  assign in_ready = !s1_valid || adv;
  assign accept   = in_valid && in_ready;

  rdb_ptr #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ptr (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .opcode     (opcode),
    .dec        (dec),
    .addr       (addr),
    .fill_after (fill_after)
  );

  // Writes land as stage 1 retires; one write and one read per cycle.
  assign wr_en   = s1_valid && adv && s1_dec.wr_en;
  assign cur     = byp_hit ? byp_data : rd_data;
  assign wr_data = s1_dec.wr_inc ? cur + s1_value : s1_value;

  rdb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (wr_data)
  );

  // Memory reads return the old entry when written at the same edge: forward
  // the retiring write to the word entering stage 1.
  always_ff @(posedge clk) begin
    if (accept) begin
      byp_hit  <= wr_en && (s1_addr == addr);
      byp_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_dec   <= dec;
      s1_addr  <= addr;
      s1_value <= value;
      s1_fill  <= fill_after;
    end
  end

  // Zero-extend the fill level, then keep the low count bits.
  assign fill_ext = {{rdb_pkg::CNT_W{1'b0}}, s1_fill};

  // Result register: holds the word until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      status <= s1_dec.refused ? rdb_pkg::ST_REFUSED : rdb_pkg::ST_DONE;
      data   <= s1_dec.ret_data ? cur : '0;
      count  <= fill_ext[rdb_pkg::CNT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_refused_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rdb_pkg::ST_REFUSED) |-> (data == '0))
    else $error("refused result carries nonzero data");

  a_write_needs_word: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (s1_valid && !s1_dec.refused))
    else $error("entry write without a live, accepted word");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |-> out_valid)
    else $error("stage 1 stalled with result register empty");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word lost before stage 1");

  a_s1_drains: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && adv && !accept) |=> (out_valid && !s1_valid))
    else $error("stage 1 word not moved to result register");
`endif

endmodule

FILE: test/ring_deque_buffer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_deque_buffer_tb: self-checking bench for the ring deque buffer
// Drives opcode/value words through valid/ready, mirrors the ring in a local
// shadow model, and compares every result word field by field.
// ----------------------------------------------------------------------------
module ring_deque_buffer_tb;

  localparam int RING_DEPTH = rdb_pkg::DEPTH_DEF;
  localparam int RING_FULL  = RING_DEPTH - 1;

  // Opcodes past untake are reserved; the block answers them as refused.
  localparam logic [rdb_pkg::OP_W-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [rdb_pkg::OP_W-1:0] OP_RSVD_HI = 3'd7;

  localparam int GAP_PCT       = 35;    // idle odds per cycle, in percent
  localparam int HOLD_CYCLES   = 150;   // long result-side hold-off
  localparam int SETTLE_CYCLES = 20;    // quiet time after the last result
  localparam int STALL_LIMIT   = 1000;  // cycles with no handshake at all

  typedef struct packed {
    logic                              status;
    logic signed [rdb_pkg::DATA_W-1:0] data;
    logic [rdb_pkg::CNT_W-1:0]         count;
  } ring_result_t;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [rdb_pkg::OP_W-1:0]          opcode    = rdb_pkg::OP_ADD;
  logic signed [rdb_pkg::DATA_W-1:0] value     = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              status;
  logic signed [rdb_pkg::DATA_W-1:0] data;
  logic [rdb_pkg::CNT_W-1:0]         count;

  // Results predicted at input accept, oldest first.
  ring_result_t                      pending_results[$];

  // Shadow of the ring: entries, which slots were ever written, and pointers.
  logic signed [rdb_pkg::DATA_W-1:0] ring_mem  [RING_DEPTH];
  bit                                ring_seen [RING_DEPTH];
  int                                head_q = 0;
  int                                tail_q = 0;
  int                                fill_q = 0;

  int                                err_count   = 0;
  int                                idle_cycles = 0;
  bit                                no_gaps     = 1'b0;  // both sides stream without idling
  bit                                hold_req    = 1'b0;  // ask the receiver for a long hold-off

  ring_deque_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .data      (data),
    .count     (count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow model of the ring
  // --------------------------------------------------------------------------

  function automatic int ring_after(input int idx);
    return (idx + 1 >= RING_DEPTH) ? 0 : idx + 1;
  endfunction

  function automatic int ring_before(input int idx);
    return (idx == 0) ? RING_DEPTH - 1 : idx - 1;
  endfunction

  // Apply one accepted word to the shadow ring and queue the result it owes.
  task automatic model_word(input logic [rdb_pkg::OP_W-1:0] op,
                            input logic signed [rdb_pkg::DATA_W-1:0] val);
    ring_result_t res;
    int           slot;
    res.status = rdb_pkg::ST_DONE;
    res.data   = '0;
    case (op)
      rdb_pkg::OP_ADD: begin
        // Refuse when the head would land on the tail: one slot always stays free.
        slot = ring_after(head_q);
        if (slot == tail_q) begin
          res.status = rdb_pkg::ST_REFUSED;
        end else begin
          ring_mem[head_q]  = val;
          ring_seen[head_q] = 1'b1;
          head_q            = slot;
          fill_q++;
        end
      end
      rdb_pkg::OP_INC: begin
        if (fill_q == 0) begin
          res.status = rdb_pkg::ST_REFUSED;
        end else begin
          // Sum wraps at the entry width.
          slot           = ring_before(head_q);
          ring_mem[slot] = ring_mem[slot] + val;
        end
      end
      rdb_pkg::OP_TAKE: begin
        if (fill_q == 0) begin
          res.status = rdb_pkg::ST_REFUSED;
        end else begin
          res.data = ring_mem[tail_q];
          tail_q   = ring_after(tail_q);
          fill_q--;
        end
      end
      rdb_pkg::OP_POP: begin
        if (fill_q == 0) begin
          res.status = rdb_pkg::ST_REFUSED;
        end else begin
          head_q   = ring_before(head_q);
          res.data = ring_mem[head_q];
          fill_q--;
        end
      end
      rdb_pkg::OP_UNTAKE: begin
        if (fill_q >= RING_FULL) begin
          res.status = rdb_pkg::ST_REFUSED;
        end else begin
          tail_q = ring_before(tail_q);
          fill_q++;
        end
      end
      default: begin
        res.status = rdb_pkg::ST_REFUSED;
      end
    endcase
    res.count = rdb_pkg::CNT_W'(fill_q);
    pending_results.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Bias toward the signed extremes and all ones now and then; otherwise any 16-bit word.
  function automatic logic signed [rdb_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'shFFFF;
      default: return rdb_pkg::DATA_W'($urandom());
    endcase
  endfunction

  // Offer one word. Call at a falling edge; returns at the falling edge after
  // the accept. Valid stays high with a steady payload until the handshake.
  task automatic offer_word(input logic [rdb_pkg::OP_W-1:0] op,
                            input logic signed [rdb_pkg::DATA_W-1:0] val);
    while (!no_gaps && $urandom_range(99) < GAP_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode   = op;
    value    = val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_word(op, val);
    @(negedge clk);
  endtask

  // Pick a weighted random operation (weights in percent, the rest reserved
  // opcodes) and send it.
  task automatic random_word(input int add_w, input int inc_w, input int take_w,
                             input int pop_w, input int untake_w);
    int                       roll;
    logic [rdb_pkg::OP_W-1:0] op;
    roll = $urandom_range(99);
    if (roll < add_w)                                  op = rdb_pkg::OP_ADD;
    else if (roll < add_w + inc_w)                     op = rdb_pkg::OP_INC;
    else if (roll < add_w + inc_w + take_w)            op = rdb_pkg::OP_TAKE;
    else if (roll < add_w + inc_w + take_w + pop_w)    op = rdb_pkg::OP_POP;
    else if (roll < add_w + inc_w + take_w + pop_w + untake_w) op = rdb_pkg::OP_UNTAKE;
    else op = rdb_pkg::OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    // An untake that uncovers a slot never written would make later reads
    // undefined; add instead so every slot inside the ring holds real data.
    if (op == rdb_pkg::OP_UNTAKE && fill_q < RING_FULL && !ring_seen[ring_before(tail_q)])
      op = rdb_pkg::OP_ADD;
    offer_word(op, rand_value());
  endtask

  // Drop valid and hold off until every predicted result has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty-ring refusals, reserved opcodes, wrap of increment, both ends, untake.
  task automatic test_directed();
    offer_word(rdb_pkg::OP_TAKE, rand_value());  // empty: refused
    offer_word(rdb_pkg::OP_POP,  rand_value());  // empty: refused
    offer_word(rdb_pkg::OP_INC,  rand_value());  // empty: refused
    for (int op = OP_RSVD_LO; op <= OP_RSVD_HI; op++)
      offer_word(rdb_pkg::OP_W'(op), rand_value());  // reserved: refused, no change
    offer_word(rdb_pkg::OP_ADD, 16'sh7FFF);
    offer_word(rdb_pkg::OP_INC, 16'sh0001);      // max + 1 wraps to min
    offer_word(rdb_pkg::OP_POP, 16'sh0000);
    offer_word(rdb_pkg::OP_ADD, 16'sh8000);
    offer_word(rdb_pkg::OP_ADD, 16'sh0000);
    offer_word(rdb_pkg::OP_ADD, 16'shFFFF);
    offer_word(rdb_pkg::OP_ADD, 16'sh7FFF);
    offer_word(rdb_pkg::OP_INC, 16'sh8000);      // newest becomes all ones
    offer_word(rdb_pkg::OP_TAKE,   rand_value());
    offer_word(rdb_pkg::OP_UNTAKE, rand_value()); // restore the word just taken
    offer_word(rdb_pkg::OP_TAKE,   rand_value());
    offer_word(rdb_pkg::OP_TAKE,   rand_value());
    offer_word(rdb_pkg::OP_POP,    rand_value());
    offer_word(rdb_pkg::OP_POP,    rand_value());
    offer_word(rdb_pkg::OP_TAKE,   rand_value()); // empty again: refused
    offer_word(rdb_pkg::OP_UNTAKE, rand_value()); // reopen a written slot
    offer_word(rdb_pkg::OP_POP,    rand_value());
    drain_results();
  endtask

  // Hold the result side off for a long stretch while words keep coming, so
  // the pipeline backs up and in_ready drops.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (24) random_word(60, 10, 10, 10, 5);
    drain_results();
  endtask

  // Fill the ring to DEPTH-1 with mostly adds, with a gap-free stretch in the
  // middle, then hit the full-ring refusals.
  task automatic test_fill_ring();
    int n;
    n = 0;
    while (fill_q < RING_FULL) begin
      no_gaps = (n >= 200 && n < 450);
      random_word(97, 1, 0, 0, 1);
      n++;
    end
    no_gaps = 1'b0;
    offer_word(rdb_pkg::OP_ADD,    rand_value()); // full: refused
    offer_word(rdb_pkg::OP_UNTAKE, rand_value()); // full: refused
    offer_word(rdb_pkg::OP_INC,    rand_value());
    offer_word(rdb_pkg::OP_POP,    rand_value());
    offer_word(rdb_pkg::OP_ADD,    rand_value()); // back to full
    offer_word(rdb_pkg::OP_ADD,    rand_value()); // full: refused
    drain_results();
  endtask

  // Balanced mix from a full ring, reserved opcodes sprinkled in as noise.
  task automatic test_random_mix();
    repeat (30) random_word(22, 15, 22, 20, 13);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic signed [31:0] want,
                                 input logic signed [31:0] got);
    $display("%0t ns: MISMATCH %s: expected %0d, got %0d", $time, what, want, got);
    err_count++;
  endtask

  // Compare each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    ring_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending, count", 0, count);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) report_mismatch("status", want.status, status);
        if (data   !== want.data)   report_mismatch("data",   want.data,   data);
        if (count  !== want.count)  report_mismatch("count",  want.count,  count);
      end
    end
  end

  // Result-side ready: random idling, a gap-free mode, and one long hold-off
  // on request, counted here in cycles.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = no_gaps || ($urandom_range(99) >= GAP_PCT);
    end
  end

  // Abort when no word moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backpressure();
    test_fill_ring();
    test_random_mix();

    // Wait out the last results, then give stray words time to show up.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
design/rdb_pkg.sv
design/rdb_mem.sv
design/rdb_ptr.sv
design/ring_deque_buffer.sv
test/ring_deque_buffer_tb.sv
